FILE: rtl/smvc_pkg.sv
package smvc_pkg;

    localparam int AXES_DEF = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_TSTEP    = 3'd1;
    localparam logic [2:0] CFG_INV_TSTEP = 3'd2;
    localparam logic [2:0] CFG_GRAVITY  = 3'd3;
    localparam logic [2:0] CFG_KV       = 3'd4;
    localparam logic [2:0] CFG_KR       = 3'd5;
    localparam logic [2:0] CFG_KS       = 3'd6;
    localparam logic [2:0] CFG_KI       = 3'd7;

    // controller modes
    localparam logic [1:0] MODE_PROP   = 2'd0;
    localparam logic [1:0] MODE_SUPER  = 2'd1;
    localparam logic [1:0] MODE_NESTED = 2'd2;

    localparam logic [1:0] Z_AXIS = 2'd2;

    // reset values
    localparam logic [1:0]         MODE_RST  = MODE_PROP;
    localparam logic [16:0]        TSTEP_RST = 17'd655;
    localparam logic [31:0]        INV_RST   = 32'd6553600;
    localparam logic signed [31:0] GRAV_RST  = 32'sd642908;
    localparam logic [47:0]        KV_RST    = 48'h0300_0300_0300;
    localparam logic [47:0]        KR_RST    = 48'h0600_0600_0600;
    localparam logic [47:0]        KS_RST    = 48'h0400_0400_0400;
    localparam logic [47:0]        KI_RST    = 48'h0400_0400_0400;

    localparam logic [4:0] CBRT_ITER = 5'd27;
    localparam logic [4:0] SQRT_ITER = 5'd24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_P1,
        ST_P2,
        ST_SURF,
        ST_ROOT,
        ST_PTMUL,
        ST_PT,
        ST_MMUL,
        ST_MREAD,
        ST_UPD,
        ST_RHI,
        ST_RLO,
        ST_RATE,
        ST_OUT
    } t_state;

    function automatic logic [15:0] gain_sel(input logic [47:0] g, input logic [1:0] a);
        logic [15:0] r;
        case (a)
            2'd0:    r = g[15:0];
            2'd1:    r = g[31:16];
            2'd2:    r = g[47:32];
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -70'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/sliding_mode_velocity_controller.sv
// Time from input word to result word is shortest in proportional mode and longest in
// nested mode; the 24-step square root and the 27-step cube root in the shared root
// unit set most of it in the sliding modes, one product per cycle the rest.
// One word at a time: the next input word is taken the cycle after the result is taken.
// Synchronous active-low reset restores the configuration registers to their defaults and clears
// the per-axis integrals and previous commands.
module sliding_mode_velocity_controller import smvc_pkg::*; #(
    parameter int AXES = AXES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_axis,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_acceleration,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_target_acceleration,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_axis_out,
    output logic signed [31:0] o_command,
    output logic signed [31:0] o_command_rate
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    t_state r_state, n_state;

    logic [1:0]         r_mode;
    logic [16:0]        r_ts;
    logic [31:0]        r_its;
    logic signed [31:0] r_grav;
    logic [47:0]        r_kv_all, r_kr_all, r_ks_all, r_ki_all;

    logic [1:0]         r_axis;
    logic signed [32:0] r_ep, r_ev, r_ea;
    logic [15:0]        r_kv, r_kr, r_ks, r_ki;
    logic signed [67:0] r_prod;
    logic               r_ep_pos, r_ep_neg, r_x_pos, r_x_neg;
    logic [32:0]        r_m;
    logic signed [31:0] r_u;
    logic [32:0]        r_md;
    logic               r_dneg;
    logic [49:0]        r_q1;
    logic [1:0]         r_out_axis;
    logic signed [31:0] r_cmd, r_rate;

    logic [80:0] r_rad;
    logic [55:0] r_rem;
    logic [26:0] r_y;
    logic [53:0] r_y2;
    logic [4:0]  r_cnt;
    logic        r_cube;

    logic signed [31:0] r_integ [AXES];
    logic signed [31:0] r_prev  [AXES];

    logic               slide, in_acc;
    logic signed [33:0] mul_a, mul_b;
    logic signed [31:0] grav, eps, x_val, u_p, rate_p, i_next, u_s, rate_s;
    logic [31:0]        e_abs, x_abs;
    logic signed [67:0] p_fl;
    logic signed [69:0] pt, inc_s, m_s;
    logic signed [32:0] d_val;
    logic [50:0]        q_sum;
    logic [26:0]        y_sh;
    logic [53:0]        y2_sh;
    logic [58:0]        trial, rem_sh, diff;
    logic               take;

    assign slide  = (r_mode == MODE_SUPER) || (r_mode == MODE_NESTED);
    assign in_acc = i_in_valid && !o_in_stall;
    assign grav   = (r_axis == Z_AXIS) ? r_grav : 32'sd0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid && (int'(i_axis) < AXES)) n_state = ST_MUL0;
            ST_MUL0:  n_state = slide ? ST_SURF : ST_P1;
            ST_P1:    n_state = ST_P2;
            ST_P2:    n_state = ST_OUT;
            ST_SURF:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_cnt == 5'd0) n_state = r_cube ? ST_PTMUL : ST_MMUL;
            end
            ST_PTMUL: n_state = ST_PT;
            ST_PT:    n_state = ST_ROOT;
            ST_MMUL:  n_state = ST_MREAD;
            ST_MREAD: n_state = ST_UPD;
            ST_UPD:   n_state = ST_RHI;
            ST_RHI:   n_state = ST_RLO;
            ST_RLO:   n_state = ST_RATE;
            ST_RATE:  n_state = ST_OUT;
            ST_OUT:   if (!i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MUL0: begin
                if (r_mode == MODE_SUPER) begin
                    mul_a = {18'd0, r_ks};
                    mul_b = 34'(r_ep);
                end else if (r_mode == MODE_NESTED) begin
                    mul_a = {2'd0, e_abs};
                    mul_b = {2'd0, e_abs};
                end else begin
                    mul_a = {18'd0, r_kv};
                    mul_b = 34'(r_ev);
                end
            end
            ST_P1: begin
                mul_a = {18'd0, r_kv};
                mul_b = 34'(r_ea);
            end
            ST_PTMUL: begin
                mul_a = {18'd0, r_ks};
                mul_b = {7'd0, r_y};
            end
            ST_MMUL: begin
                mul_a = {18'd0, r_kr};
                mul_b = {7'd0, r_y};
            end
            ST_MREAD: begin
                mul_a = {17'd0, r_ts};
                mul_b = {18'd0, r_ki};
            end
            ST_RHI: begin
                mul_a = {17'd0, r_md[32:16]};
                mul_b = {2'd0, r_its};
            end
            ST_RLO: begin
                mul_a = {18'd0, r_md[15:0]};
                mul_b = {2'd0, r_its};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // arithmetic around the shared multiplier
    always_comb begin
        eps    = sat32(70'(r_ep));
        e_abs  = eps[31] ? (~eps + 32'd1) : eps;
        p_fl   = (-r_prod) >>> 8;
        u_p    = sat32(70'(p_fl) - 70'(grav));
        rate_p = sat32(70'(p_fl));
        pt     = 70'(r_prod >>> 8);
        if (r_state == ST_SURF) begin
            x_val = sat32(70'(r_ev) + 70'(r_prod >>> 8));
        end else begin
            x_val = sat32(70'(r_ev) + (r_ep_pos ? pt : (r_ep_neg ? -pt : 70'sd0)));
        end
        x_abs  = x_val[31] ? (~x_val + 32'd1) : x_val;
        inc_s  = 70'($signed({1'b0, r_prod[32:8]}));
        m_s    = 70'($signed({1'b0, r_m}));
        i_next = sat32(70'(r_integ[r_axis[AW-1:0]])
                       - (r_x_pos ? inc_s : (r_x_neg ? -inc_s : 70'sd0)));
        u_s    = sat32((r_x_pos ? -m_s : (r_x_neg ? m_s : 70'sd0))
                       + 70'(i_next) - 70'(grav));
        d_val  = 33'(u_s) - 33'(r_prev[r_axis[AW-1:0]]);
        q_sum  = 51'(r_q1) + 51'(r_prod[49:16]);
        if (r_ts == 17'd0) begin
            rate_s = 32'sd0;
        end else if (r_dneg) begin
            rate_s = sat32(-70'($signed({1'b0, q_sum})));
        end else begin
            rate_s = sat32(70'($signed({1'b0, q_sum})));
        end
    end

    // root unit: one digit per cycle, base 8 for cube root, base 4 for square root
    always_comb begin
        y_sh  = {r_y[25:0], 1'b0};
        y2_sh = {r_y2[51:0], 2'b00};
        if (r_cube) begin
            trial  = 59'({y2_sh, 1'b0}) + 59'(y2_sh) + 59'({y_sh, 1'b0}) + 59'(y_sh) + 59'd1;
            rem_sh = {r_rem, r_rad[80:78]};
        end else begin
            trial  = 59'({y_sh, 1'b1});
            rem_sh = {1'b0, r_rem, r_rad[80:79]};
        end
        take = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MODE_RST;
            r_ts     <= TSTEP_RST;
            r_its    <= INV_RST;
            r_grav   <= GRAV_RST;
            r_kv_all <= KV_RST;
            r_kr_all <= KR_RST;
            r_ks_all <= KS_RST;
            r_ki_all <= KI_RST;
            for (int i = 0; i < AXES; i++) begin
                r_integ[i] <= 32'sd0;
                r_prev[i]  <= 32'sd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:      r_mode   <= i_cfg_data[1:0];
                    CFG_TSTEP:     r_ts     <= i_cfg_data[16:0];
                    CFG_INV_TSTEP: r_its    <= i_cfg_data[31:0];
                    CFG_GRAVITY:   r_grav   <= i_cfg_data[31:0];
                    CFG_KV:        r_kv_all <= i_cfg_data;
                    CFG_KR:        r_kr_all <= i_cfg_data;
                    CFG_KS:        r_ks_all <= i_cfg_data;
                    CFG_KI:        r_ki_all <= i_cfg_data;
                    default:       r_mode   <= r_mode;
                endcase
            end
            if (r_state == ST_UPD) r_integ[r_axis[AW-1:0]] <= i_next;
            if (r_state == ST_P2 || r_state == ST_RATE) r_prev[r_axis[AW-1:0]] <= r_u;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc) begin
            r_axis <= i_axis;
            r_ep   <= 33'(i_position) - 33'(i_target_position);
            r_ev   <= 33'(i_velocity) - 33'(i_target_velocity);
            r_ea   <= 33'(i_acceleration) - 33'(i_target_acceleration);
            r_kv   <= gain_sel(r_kv_all, i_axis);
            r_kr   <= gain_sel(r_kr_all, i_axis);
            r_ks   <= gain_sel(r_ks_all, i_axis);
            r_ki   <= gain_sel(r_ki_all, i_axis);
        end
        case (r_state)
            ST_MUL0: begin
                r_ep_pos <= (eps > 32'sd0);
                r_ep_neg <= eps[31];
            end
            ST_P1: r_u <= u_p;
            ST_P2: begin
                r_out_axis <= r_axis;
                r_cmd      <= r_u;
                r_rate     <= rate_p;
            end
            ST_SURF, ST_PT: begin
                r_rem <= '0;
                r_y   <= '0;
                r_y2  <= '0;
                if (r_state == ST_SURF && r_mode == MODE_NESTED) begin
                    r_cube <= 1'b1;
                    r_cnt  <= CBRT_ITER - 5'd1;
                    // e^2 reaches 2^62 when the position error saturates negative
                    r_rad  <= {2'd0, r_prod[62:0], 16'd0};
                end else begin
                    r_cube  <= 1'b0;
                    r_cnt   <= SQRT_ITER - 5'd1;
                    r_rad   <= {x_abs, 49'd0};
                    r_x_pos <= (x_val > 32'sd0);
                    r_x_neg <= x_val[31];
                end
            end
            ST_ROOT: begin
                r_cnt <= r_cnt - 5'd1;
                r_rad <= r_cube ? {r_rad[77:0], 3'd0} : {r_rad[78:0], 2'd0};
                if (take) begin
                    r_rem <= diff[55:0];
                    r_y   <= y_sh | 27'd1;
                    r_y2  <= y2_sh + {r_y2[52:0], 1'b0} * 54'd0 + 54'({y_sh, 1'b0}) + 54'd1;
                end else begin
                    r_rem <= rem_sh[55:0];
                    r_y   <= y_sh;
                    r_y2  <= y2_sh;
                end
            end
            ST_MREAD: r_m <= r_prod[40:8];
            ST_UPD: begin
                r_u    <= u_s;
                r_dneg <= d_val[32];
                r_md   <= d_val[32] ? (~d_val + 33'd1) : d_val;
            end
            ST_RLO: r_q1 <= r_prod[49:0];
            ST_RATE: begin
                r_out_axis <= r_axis;
                r_cmd      <= r_u;
                r_rate     <= rate_s;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_axis_out     = r_out_axis;
    assign o_command      = r_cmd;
    assign o_command_rate = r_rate;

endmodule

FILE: rtl/smvc_checker.sv
module smvc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_axis_out,
    input logic signed [31:0] o_command,
    input logic signed [31:0] o_command_rate
);

    // a held result word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_command)
            && $stable(o_command_rate) && $stable(o_axis_out))
        else $error("result word changed while stalled");

    // no new word is taken while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // an accepted word keeps the block busy
    a_busy_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared right after accept");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind sliding_mode_velocity_controller smvc_checker u_smvc_checker (.*);
